// ===== src/rba_pkg.sv =====
// ----------------------------------------------------------------------------
// rba_pkg
// Shared widths, types and rounding helpers for the angular acceleration
// pipeline.
// ----------------------------------------------------------------------------
package rba_pkg;

    localparam int QW = 48;     // fixed point word
    localparam int PW = 96;     // exact product of two words
    localparam int SW = 100;    // headroom for a sum of three products
    localparam int HW = 24;     // half word for partial products

    typedef logic signed [QW-1:0] q_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [SW-1:0] sum_t;

    localparam q_t QMAX = {1'b0, {(QW-1){1'b1}}};
    localparam q_t QMIN = {1'b1, {(QW-1){1'b0}}};

    typedef struct packed {
        logic signed [QW-1:0] value;
        logic                 ovf;
    } rnd_t;

    // Add half an LSB, drop f fraction bits, clamp to a word.
    function automatic rnd_t round_sat(input sum_t v, input int f);
        sum_t s;
        rnd_t r;
        s = (v + (sum_t'(1) <<< (f - 1))) >>> f;
        if (s > sum_t'(QMAX))
        begin
            r.value = QMAX;
            r.ovf   = 1'b1;
        end
        else if (s < sum_t'(QMIN))
        begin
            r.value = QMIN;
            r.ovf   = 1'b1;
        end
        else
        begin
            r.value = s[QW-1:0];
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

    // Clamp a word-plus-one difference to a word.
    function automatic rnd_t sat_diff(input q_t a, input q_t b);
        logic signed [QW:0] d;
        rnd_t r;
        d = (QW+1)'(a) - (QW+1)'(b);
        if (d > (QW+1)'(QMAX))
        begin
            r.value = QMAX;
            r.ovf   = 1'b1;
        end
        else if (d < (QW+1)'(QMIN))
        begin
            r.value = QMIN;
            r.ovf   = 1'b1;
        end
        else
        begin
            r.value = d[QW-1:0];
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== src/rba_mul.sv =====
// ----------------------------------------------------------------------------
// rba_mul
// Two-stage exact signed word by word multiplier built from four half-word
// partial products.
// ----------------------------------------------------------------------------
module rba_mul (
    input  logic          clk,
    input  logic          en,
    input  rba_pkg::q_t   a,
    input  rba_pkg::q_t   b,
    output rba_pkg::prod_t p
);
    import rba_pkg::*;

    // signed high halves, unsigned low halves carried as positive signed
    logic signed [HW-1:0] ah, bh;
    logic signed [HW:0]   al, bl;

    logic signed [2*HW-1:0] hh_reg;
    logic signed [2*HW:0]   hl_reg, lh_reg;
    logic signed [2*HW+1:0] ll_reg;
    prod_t                  p_reg;

    assign ah = a[QW-1:HW];
    assign bh = b[QW-1:HW];
    assign al = {1'b0, a[HW-1:0]};
    assign bl = {1'b0, b[HW-1:0]};

    // stage 1: partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hh_reg <= ah * bh;
            hl_reg <= ah * bl;
            lh_reg <= al * bh;
            ll_reg <= al * bl;
        end
    end

    // stage 2: align and sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= (prod_t'(hh_reg) <<< (2*HW)) + (prod_t'(hl_reg) <<< HW)
                   + (prod_t'(lh_reg) <<< HW) + prod_t'(ll_reg);
        end
    end

    assign p = p_reg;

endmodule

// ===== src/rigid_body_angular_acceleration.sv =====
// ----------------------------------------------------------------------------
// rigid_body_angular_acceleration
// Pipelined Euler rotational equation: alpha = inv(I) (M - w x (I w)).
// ----------------------------------------------------------------------------
// A new beat is taken every cycle unless the output is stalled, and its
// result leaves in order. The datapath is three exact 48x48 multiply passes
// (with rounding and subtract stages between them) followed by a restoring
// divider that resolves one quotient bit per stage over 48 stages. A stall
// on the output freezes the whole pipeline and is passed back to the input.
// A zero determinant gives zero outputs with singular set and overflow clear;
// otherwise overflow reports any clamp along the way.
module rigid_body_angular_acceleration #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  rba_pkg::q_t rate_x,
    input  rba_pkg::q_t rate_y,
    input  rba_pkg::q_t rate_z,
    input  rba_pkg::q_t moment_x,
    input  rba_pkg::q_t moment_y,
    input  rba_pkg::q_t moment_z,
    input  rba_pkg::q_t inertia_xx,
    input  rba_pkg::q_t inertia_yy,
    input  rba_pkg::q_t inertia_zz,
    input  rba_pkg::q_t inertia_xy,
    input  rba_pkg::q_t inertia_xz,
    input  rba_pkg::q_t inertia_yz,
    output logic        out_valid,
    input  logic        out_stall,
    output rba_pkg::q_t accel_x,
    output rba_pkg::q_t accel_y,
    output rba_pkg::q_t accel_z,
    output logic        singular,
    output logic        overflow
);
    import rba_pkg::*;

    localparam int DS  = 11;          // stage holding divider setup
    localparam int LAT = DS + QW + 1; // output register stage

    logic adv;
    logic v_reg [1:LAT];

    // multiplier operands and products per pass
    q_t    a1 [0:20], b1 [0:20];
    prod_t p1 [0:20];
    q_t    a2 [0:8],  b2 [0:8];
    prod_t p2 [0:8];
    q_t    a3 [0:8],  b3 [0:8];
    prod_t p3 [0:8];

    // delay lines
    q_t   w_d_reg  [1:3][0:2];
    q_t   ia_d_reg [1:3][0:2];
    q_t   m_d_reg  [1:6][0:2];
    q_t   c_d_reg  [3:7][0:5];
    q_t   h_reg    [0:2];
    q_t   g_reg    [0:2];
    q_t   r_reg    [0:2];
    q_t   det_d_reg [6:10];
    logic ovf_d_reg [3:10];
    sum_t n_reg    [0:2];

    // divider pipeline
    logic [QW-1:0] dv_rem_reg [0:QW][0:2];
    logic [QW-1:0] dv_mlo_reg [0:QW][0:2];
    logic [QW-1:0] dv_q_reg   [0:QW][0:2];
    logic          dv_neg_reg [0:QW][0:2];
    logic          dv_ofq_reg [0:QW][0:2];
    logic [QW-1:0] dv_dm_reg  [0:QW];
    logic          dv_ovf_reg [0:QW];
    logic          dv_sing_reg [0:QW];

    q_t   accel_reg [0:2];
    logic singular_reg, overflow_reg;

    // handshake: whole pipeline moves unless the output beat is held
    assign adv       = !(v_reg[LAT] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = v_reg[LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAT; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[1] <= in_valid;
            for (int k = 2; k <= LAT; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // pass 1 operands: I w and cofactor products
    always_comb
    begin
        a1[0]  = inertia_xx; b1[0]  = rate_x;
        a1[1]  = inertia_xy; b1[1]  = rate_y;
        a1[2]  = inertia_xz; b1[2]  = rate_z;
        a1[3]  = inertia_xy; b1[3]  = rate_x;
        a1[4]  = inertia_yy; b1[4]  = rate_y;
        a1[5]  = inertia_yz; b1[5]  = rate_z;
        a1[6]  = inertia_xz; b1[6]  = rate_x;
        a1[7]  = inertia_yz; b1[7]  = rate_y;
        a1[8]  = inertia_zz; b1[8]  = rate_z;
        a1[9]  = inertia_yy; b1[9]  = inertia_zz;
        a1[10] = inertia_yz; b1[10] = inertia_yz;
        a1[11] = inertia_xx; b1[11] = inertia_zz;
        a1[12] = inertia_xz; b1[12] = inertia_xz;
        a1[13] = inertia_xx; b1[13] = inertia_yy;
        a1[14] = inertia_xy; b1[14] = inertia_xy;
        a1[15] = inertia_xz; b1[15] = inertia_yz;
        a1[16] = inertia_xy; b1[16] = inertia_zz;
        a1[17] = inertia_xy; b1[17] = inertia_yz;
        a1[18] = inertia_xz; b1[18] = inertia_yy;
        a1[19] = inertia_xy; b1[19] = inertia_xz;
        a1[20] = inertia_xx; b1[20] = inertia_yz;
    end

    // pass 2 operands: w x h and determinant
    always_comb
    begin
        a2[0] = w_d_reg[3][1];  b2[0] = h_reg[2];
        a2[1] = w_d_reg[3][2];  b2[1] = h_reg[1];
        a2[2] = w_d_reg[3][2];  b2[2] = h_reg[0];
        a2[3] = w_d_reg[3][0];  b2[3] = h_reg[2];
        a2[4] = w_d_reg[3][0];  b2[4] = h_reg[1];
        a2[5] = w_d_reg[3][1];  b2[5] = h_reg[0];
        a2[6] = ia_d_reg[3][0]; b2[6] = c_d_reg[3][0];
        a2[7] = ia_d_reg[3][1]; b2[7] = c_d_reg[3][3];
        a2[8] = ia_d_reg[3][2]; b2[8] = c_d_reg[3][4];
    end

    // pass 3 operands: adjugate times residual moment
    // cofactor order: xx, yy, zz, xy, xz, yz
    always_comb
    begin
        a3[0] = c_d_reg[7][0]; b3[0] = r_reg[0];
        a3[1] = c_d_reg[7][3]; b3[1] = r_reg[1];
        a3[2] = c_d_reg[7][4]; b3[2] = r_reg[2];
        a3[3] = c_d_reg[7][3]; b3[3] = r_reg[0];
        a3[4] = c_d_reg[7][1]; b3[4] = r_reg[1];
        a3[5] = c_d_reg[7][5]; b3[5] = r_reg[2];
        a3[6] = c_d_reg[7][4]; b3[6] = r_reg[0];
        a3[7] = c_d_reg[7][5]; b3[7] = r_reg[1];
        a3[8] = c_d_reg[7][2]; b3[8] = r_reg[2];
    end

    for (genvar i = 0; i < 21; i++)
    begin : g_mul1
        rba_mul u_mul (.clk(clk), .en(adv), .a(a1[i]), .b(b1[i]), .p(p1[i]));
    end
    for (genvar i = 0; i < 9; i++)
    begin : g_mul23
        rba_mul u_mul2 (.clk(clk), .en(adv), .a(a2[i]), .b(b2[i]), .p(p2[i]));
        rba_mul u_mul3 (.clk(clk), .en(adv), .a(a3[i]), .b(b3[i]), .p(p3[i]));
    end

    // arithmetic stages between multiplier passes
    always_ff @(posedge clk)
    begin
        rnd_t rh [0:2];
        rnd_t rc [0:5];
        rnd_t rg [0:2];
        rnd_t rd;
        rnd_t rr [0:2];
        logic o3, o6, o7;
        if (adv)
        begin
            // input delay line
            w_d_reg[1][0]  <= rate_x;     w_d_reg[1][1]  <= rate_y;
            w_d_reg[1][2]  <= rate_z;
            ia_d_reg[1][0] <= inertia_xx; ia_d_reg[1][1] <= inertia_xy;
            ia_d_reg[1][2] <= inertia_xz;
            m_d_reg[1][0]  <= moment_x;   m_d_reg[1][1]  <= moment_y;
            m_d_reg[1][2]  <= moment_z;
            for (int k = 2; k <= 3; k++)
            begin
                w_d_reg[k]  <= w_d_reg[k-1];
                ia_d_reg[k] <= ia_d_reg[k-1];
            end
            for (int k = 2; k <= 6; k++)
            begin
                m_d_reg[k] <= m_d_reg[k-1];
            end

            // stage 3: round I w and cofactors
            o3 = 1'b0;
            for (int j = 0; j < 3; j++)
            begin
                rh[j] = round_sat(sum_t'(p1[3*j]) + sum_t'(p1[3*j+1])
                                  + sum_t'(p1[3*j+2]), FRAC_BITS);
                h_reg[j] <= rh[j].value;
                o3 = o3 | rh[j].ovf;
            end
            for (int j = 0; j < 6; j++)
            begin
                rc[j] = round_sat(sum_t'(p1[9+2*j]) - sum_t'(p1[10+2*j]), FRAC_BITS);
                c_d_reg[3][j] <= rc[j].value;
                o3 = o3 | rc[j].ovf;
            end
            ovf_d_reg[3] <= o3;
            for (int k = 4; k <= 7; k++)
            begin
                c_d_reg[k] <= c_d_reg[k-1];
            end
            ovf_d_reg[4] <= ovf_d_reg[3];
            ovf_d_reg[5] <= ovf_d_reg[4];

            // stage 6: round gyroscopic term and determinant
            o6 = ovf_d_reg[5];
            for (int j = 0; j < 3; j++)
            begin
                rg[j] = round_sat(sum_t'(p2[2*j]) - sum_t'(p2[2*j+1]), FRAC_BITS);
                g_reg[j] <= rg[j].value;
                o6 = o6 | rg[j].ovf;
            end
            rd = round_sat(sum_t'(p2[6]) + sum_t'(p2[7]) + sum_t'(p2[8]), FRAC_BITS);
            det_d_reg[6] <= rd.value;
            ovf_d_reg[6] <= o6 | rd.ovf;

            // stage 7: residual moment
            o7 = ovf_d_reg[6];
            for (int j = 0; j < 3; j++)
            begin
                rr[j] = sat_diff(m_d_reg[6][j], g_reg[j]);
                r_reg[j] <= rr[j].value;
                o7 = o7 | rr[j].ovf;
            end
            ovf_d_reg[7] <= o7;
            for (int k = 7; k <= 10; k++)
            begin
                det_d_reg[k] <= det_d_reg[k-1];
            end
            for (int k = 8; k <= 10; k++)
            begin
                ovf_d_reg[k] <= ovf_d_reg[k-1];
            end

            // stage 10: exact numerators
            for (int j = 0; j < 3; j++)
            begin
                n_reg[j] <= sum_t'(p3[3*j]) + sum_t'(p3[3*j+1]) + sum_t'(p3[3*j+2]);
            end
        end
    end

    // divider: setup, one quotient bit per stage, final clamp
    always_ff @(posedge clk)
    begin
        logic [SW-1:0] nmag, mm;
        logic [QW-1:0] dm;
        logic [QW:0]   t;
        logic          big;
        logic          ovf_any;
        logic [QW-1:0] lim;
        if (adv)
        begin
            // setup stage: magnitudes, rounding bias, quotient range check
            dm = det_d_reg[10][QW-1] ? QW'(-det_d_reg[10]) : det_d_reg[10];
            dv_dm_reg[0]   <= dm;
            dv_ovf_reg[0]  <= ovf_d_reg[10];
            dv_sing_reg[0] <= (det_d_reg[10] == '0);
            for (int j = 0; j < 3; j++)
            begin
                nmag = n_reg[j][SW-1] ? SW'(-n_reg[j]) : n_reg[j];
                mm   = nmag + SW'(dm >> 1);
                dv_neg_reg[0][j] <= n_reg[j][SW-1] ^ det_d_reg[10][QW-1];
                dv_ofq_reg[0][j] <= (mm[SW-1:QW] >= (SW-QW)'(dm));
                dv_rem_reg[0][j] <= mm[2*QW-1:QW];
                dv_mlo_reg[0][j] <= mm[QW-1:0];
                dv_q_reg[0][j]   <= '0;
            end

            // restoring steps
            for (int k = 1; k <= QW; k++)
            begin
                dv_dm_reg[k]   <= dv_dm_reg[k-1];
                dv_ovf_reg[k]  <= dv_ovf_reg[k-1];
                dv_sing_reg[k] <= dv_sing_reg[k-1];
                for (int j = 0; j < 3; j++)
                begin
                    t = {dv_rem_reg[k-1][j], dv_mlo_reg[k-1][j][QW-1]};
                    if (t >= {1'b0, dv_dm_reg[k-1]})
                    begin
                        dv_rem_reg[k][j] <= QW'(t - {1'b0, dv_dm_reg[k-1]});
                        dv_q_reg[k][j]   <= {dv_q_reg[k-1][j][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[k][j] <= t[QW-1:0];
                        dv_q_reg[k][j]   <= {dv_q_reg[k-1][j][QW-2:0], 1'b0};
                    end
                    dv_mlo_reg[k][j] <= {dv_mlo_reg[k-1][j][QW-2:0], 1'b0};
                    dv_neg_reg[k][j] <= dv_neg_reg[k-1][j];
                    dv_ofq_reg[k][j] <= dv_ofq_reg[k-1][j];
                end
            end

            // output stage: sign, clamp, singular override
            ovf_any = dv_ovf_reg[QW];
            for (int j = 0; j < 3; j++)
            begin
                lim = dv_neg_reg[QW][j] ? QW'(QMAX) + QW'(1) : QW'(QMAX);
                big = dv_ofq_reg[QW][j] || (dv_q_reg[QW][j] > lim);
                ovf_any = ovf_any | big;
                if (dv_sing_reg[QW])
                    accel_reg[j] <= '0;
                else if (big)
                    accel_reg[j] <= dv_neg_reg[QW][j] ? QMIN : QMAX;
                else if (dv_neg_reg[QW][j])
                    accel_reg[j] <= -q_t'(dv_q_reg[QW][j]);
                else
                    accel_reg[j] <= q_t'(dv_q_reg[QW][j]);
            end
            singular_reg <= dv_sing_reg[QW];
            overflow_reg <= !dv_sing_reg[QW] && ovf_any;
        end
    end

    assign accel_x  = accel_reg[0];
    assign accel_y  = accel_reg[1];
    assign accel_z  = accel_reg[2];
    assign singular = singular_reg;
    assign overflow = overflow_reg;

endmodule

// ===== bench/rba_checker.sv =====
// ----------------------------------------------------------------------------
// rba_checker
// Watches both channels of the angular acceleration block, predicts each
// result from the accepted input beat and compares it field by field.
// ----------------------------------------------------------------------------
module rba_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  rba_pkg::q_t rate_x,
    input  rba_pkg::q_t rate_y,
    input  rba_pkg::q_t rate_z,
    input  rba_pkg::q_t moment_x,
    input  rba_pkg::q_t moment_y,
    input  rba_pkg::q_t moment_z,
    input  rba_pkg::q_t inertia_xx,
    input  rba_pkg::q_t inertia_yy,
    input  rba_pkg::q_t inertia_zz,
    input  rba_pkg::q_t inertia_xy,
    input  rba_pkg::q_t inertia_xz,
    input  rba_pkg::q_t inertia_yz,
    input  logic        out_valid,
    input  logic        out_stall,
    input  rba_pkg::q_t accel_x,
    input  rba_pkg::q_t accel_y,
    input  rba_pkg::q_t accel_z,
    input  logic        singular,
    input  logic        overflow,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rba_pkg::*;

    typedef logic signed [199:0] wide_t;

    typedef struct {
        q_t   ax;
        q_t   ay;
        q_t   az;
        logic sing;
        logic ovf;
    } accel_t;

    accel_t accel_due[$];

    localparam wide_t WMAX = wide_t'(QMAX);
    localparam wide_t WMIN = wide_t'(QMIN);

    function automatic q_t clamp(input wide_t v, inout logic ovf);
        if (v > WMAX)
        begin
            ovf = 1'b1;
            return QMAX;
        end
        if (v < WMIN)
        begin
            ovf = 1'b1;
            return QMIN;
        end
        return v[47:0];
    endfunction

    // half LSB added, arithmetic shift (floor), then clamp
    function automatic q_t rnd(input wide_t v, inout logic ovf);
        wide_t s;
        s = (v + (wide_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return clamp(s, ovf);
    endfunction

    // nearest, ties away from zero
    function automatic q_t qdiv(input wide_t n, input q_t d, inout logic ovf);
        wide_t nm;
        wide_t dm;
        wide_t q;
        logic  neg;
        neg = (n < 0) != (d < 0);
        nm  = (n < 0) ? -n : n;
        dm  = (d < 0) ? -wide_t'(d) : wide_t'(d);
        q   = (nm + (dm >>> 1)) / dm;
        return clamp(neg ? -q : q, ovf);
    endfunction

    function automatic accel_t predict_accel(
        input q_t wx, input q_t wy, input q_t wz,
        input q_t mx, input q_t my, input q_t mz,
        input q_t ixx, input q_t iyy, input q_t izz,
        input q_t ixy, input q_t ixz, input q_t iyz);
        accel_t res;
        logic   ovf;
        q_t     hx, hy, hz, gx, gy, gz, rx, ry, rz;
        q_t     cxx, cyy, czz, cxy, cxz, cyz, det;
        ovf = 1'b0;
        // angular momentum and gyroscopic term
        hx = rnd(wide_t'(ixx) * wx + wide_t'(ixy) * wy + wide_t'(ixz) * wz, ovf);
        hy = rnd(wide_t'(ixy) * wx + wide_t'(iyy) * wy + wide_t'(iyz) * wz, ovf);
        hz = rnd(wide_t'(ixz) * wx + wide_t'(iyz) * wy + wide_t'(izz) * wz, ovf);
        gx = rnd(wide_t'(wy) * hz - wide_t'(wz) * hy, ovf);
        gy = rnd(wide_t'(wz) * hx - wide_t'(wx) * hz, ovf);
        gz = rnd(wide_t'(wx) * hy - wide_t'(wy) * hx, ovf);
        rx = clamp(wide_t'(mx) - gx, ovf);
        ry = clamp(wide_t'(my) - gy, ovf);
        rz = clamp(wide_t'(mz) - gz, ovf);
        // adjugate and determinant
        cxx = rnd(wide_t'(iyy) * izz - wide_t'(iyz) * iyz, ovf);
        cyy = rnd(wide_t'(ixx) * izz - wide_t'(ixz) * ixz, ovf);
        czz = rnd(wide_t'(ixx) * iyy - wide_t'(ixy) * ixy, ovf);
        cxy = rnd(wide_t'(ixz) * iyz - wide_t'(ixy) * izz, ovf);
        cxz = rnd(wide_t'(ixy) * iyz - wide_t'(ixz) * iyy, ovf);
        cyz = rnd(wide_t'(ixy) * ixz - wide_t'(ixx) * iyz, ovf);
        det = rnd(wide_t'(ixx) * cxx + wide_t'(ixy) * cxy + wide_t'(ixz) * cxz, ovf);
        if (det == 0)
        begin
            res.ax = '0;
            res.ay = '0;
            res.az = '0;
            res.sing = 1'b1;
            res.ovf = 1'b0;
            return res;
        end
        res.ax = qdiv(wide_t'(cxx) * rx + wide_t'(cxy) * ry + wide_t'(cxz) * rz, det, ovf);
        res.ay = qdiv(wide_t'(cxy) * rx + wide_t'(cyy) * ry + wide_t'(cyz) * rz, det, ovf);
        res.az = qdiv(wide_t'(cxz) * rx + wide_t'(cyz) * ry + wide_t'(czz) * rz, det, ovf);
        res.sing = 1'b0;
        res.ovf = ovf;
        return res;
    endfunction

    assign pending = accel_due.size();

    initial
    begin
        fail_count = 0;
    end

    // input beats queue predictions, output beats consume them
    always @(posedge clk)
    begin
        accel_t exp_r;
        if (rst_n && in_valid && !in_stall)
            accel_due.push_back(predict_accel(rate_x, rate_y, rate_z,
                moment_x, moment_y, moment_z, inertia_xx, inertia_yy,
                inertia_zz, inertia_xy, inertia_xz, inertia_yz));
        if (rst_n && out_valid && !out_stall)
        begin
            if (accel_due.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                exp_r = accel_due.pop_front();
                if (accel_x !== exp_r.ax)
                begin
                    $error("accel_x expected %0d got %0d", exp_r.ax, accel_x);
                    fail_count++;
                end
                if (accel_y !== exp_r.ay)
                begin
                    $error("accel_y expected %0d got %0d", exp_r.ay, accel_y);
                    fail_count++;
                end
                if (accel_z !== exp_r.az)
                begin
                    $error("accel_z expected %0d got %0d", exp_r.az, accel_z);
                    fail_count++;
                end
                if (singular !== exp_r.sing)
                begin
                    $error("singular expected %0b got %0b", exp_r.sing, singular);
                    fail_count++;
                end
                if (overflow !== exp_r.ovf)
                begin
                    $error("overflow expected %0b got %0b", exp_r.ovf, overflow);
                    fail_count++;
                end
            end
        end
    end

endmodule

// ===== bench/rigid_body_angular_acceleration_tb.sv =====
// ----------------------------------------------------------------------------
// rigid_body_angular_acceleration_tb
// Drives directed and random beats (well-conditioned tensors, singular ones,
// extremes and raw noise) with random gaps and stalls, including a long
// output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module rigid_body_angular_acceleration_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rba_pkg::*;

    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM   = 400;
    localparam int CALM_FROM  = 340;
    localparam int LIMIT      = 200000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic out_valid;
    logic out_stall;
    q_t   fld [12];
    q_t   accel_x, accel_y, accel_z;
    logic singular, overflow;
    int   fail_count;
    int   pending;
    int   sent;
    bit   hold_done;
    int   cycles;

    rigid_body_angular_acceleration DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .rate_x(fld[0]), .rate_y(fld[1]), .rate_z(fld[2]),
        .moment_x(fld[3]), .moment_y(fld[4]), .moment_z(fld[5]),
        .inertia_xx(fld[6]), .inertia_yy(fld[7]), .inertia_zz(fld[8]),
        .inertia_xy(fld[9]), .inertia_xz(fld[10]), .inertia_yz(fld[11]),
        .out_valid(out_valid), .out_stall(out_stall),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .singular(singular), .overflow(overflow)
    );

    rba_checker CHK (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .rate_x(fld[0]), .rate_y(fld[1]), .rate_z(fld[2]),
        .moment_x(fld[3]), .moment_y(fld[4]), .moment_z(fld[5]),
        .inertia_xx(fld[6]), .inertia_yy(fld[7]), .inertia_zz(fld[8]),
        .inertia_xy(fld[9]), .inertia_xz(fld[10]), .inertia_yz(fld[11]),
        .out_valid(out_valid), .out_stall(out_stall),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .singular(singular), .overflow(overflow),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic q_t rand_word();
        return q_t'({$urandom(), $urandom()});
    endfunction

    // small magnitude value: integer part up to 2^k
    function automatic q_t rand_small(input int k);
        q_t v;
        v = q_t'({$urandom(), $urandom()}) >>> (47 - 16 - k);
        return v;
    endfunction

    // send one beat; hold payload while stalled
    task automatic send_beat(input q_t v [12], input bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge clk);
        end
        fld = v;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // output-side stalls: random bursts, one long hold-off, calm at the end
    initial
    begin
        out_stall = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!hold_done && sent > N_DIRECTED + 40)
            begin
                hold_done = 1'b1;
                out_stall = 1'b1;
                repeat (150) @(negedge clk);
                out_stall = 1'b0;
            end
            else if (sent < N_DIRECTED + CALM_FROM && $urandom_range(0, 5) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // cycle limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        q_t v [12];
        q_t one;
        int kind;
        int k;
        one = q_t'(1) <<< 16;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sent = 0;
        foreach (fld[i])
            fld[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: identity, zeros, extremes, singular, diagonal, ties
        for (int d = 0; d < N_DIRECTED; d++)
        begin
            foreach (v[i])
                v[i] = '0;
            case (d)
                0: begin v[6] = one; v[7] = one; v[8] = one; v[3] = one; end
                1: ;
                2: foreach (v[i]) v[i] = QMAX;
                3: foreach (v[i]) v[i] = QMIN;
                4: begin foreach (v[i]) v[i] = QMAX; v[9] = QMIN; v[1] = QMIN; end
                5: begin v[6] = one; v[7] = one; v[8] = one; v[9] = one; v[10] = one;
                         v[11] = one; v[0] = one; end
                6: begin v[6] = 2 * one; v[7] = 3 * one; v[8] = 5 * one;
                         v[0] = one; v[1] = -one; v[2] = 2 * one;
                         v[3] = q_t'(7); v[4] = q_t'(-7); v[5] = QMAX; end
                7: begin v[6] = 3 * one; v[7] = 3 * one; v[8] = 3 * one; v[3] = q_t'(1);
                         v[4] = q_t'(-1); v[5] = q_t'(2); end
                8: begin v[6] = q_t'(1); v[7] = q_t'(1); v[8] = q_t'(1); v[3] = one; end
                9: begin v[6] = -one; v[7] = one; v[8] = one; v[5] = QMIN; end
                10: begin foreach (v[i]) v[i] = q_t'(-1); end
                11: begin foreach (v[i]) v[i] = q_t'(1); end
                12: begin v[6] = one; v[7] = one; v[8] = one;
                          v[0] = QMAX; v[1] = QMAX; v[2] = QMIN; end
                default: foreach (v[i]) v[i] = rand_word();
            endcase
            send_beat(v, 1'b0);
        end

        // random part
        for (int n = 0; n < N_RANDOM; n++)
        begin
            kind = $urandom_range(0, 9);
            k = $urandom_range(0, 12);
            foreach (v[i])
                v[i] = rand_small(k);
            if (kind < 6)
            begin
                // diagonally dominant tensor, realistic magnitudes
                v[6] = v[6] + (one <<< k) * 4;
                v[7] = v[7] + (one <<< k) * 4;
                v[8] = v[8] + (one <<< k) * 4;
            end
            else if (kind == 6)
            begin
                // rank-deficient: rows proportional
                v[6] = v[9]; v[7] = v[9]; v[8] = v[9]; v[10] = v[9]; v[11] = v[9];
            end
            else if (kind == 7)
            begin
                foreach (v[i])
                    v[i] = rand_word();
            end
            else if (kind == 8)
            begin
                foreach (v[i])
                    if ($urandom_range(0, 2) == 0)
                        v[i] = $urandom_range(0, 1) ? QMAX : QMIN;
            end
            send_beat(v, n < CALM_FROM);
        end

        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
